FILE: design/imc_pkg.sv
package imc_pkg;

   // Field widths of one request and one response
   localparam int unsigned ActionWidth   = 2;
   localparam int unsigned RegIndexWidth = 2;
   localparam int unsigned DataWidth     = 32;
   localparam int unsigned SourceWidth   = 3;
   localparam int unsigned NumSources    = 6;
   localparam int unsigned RepeatWidth   = 7;
   localparam int unsigned ModeWidth     = 3;

   localparam logic [DataWidth-1:0]  VERSION_WORD = 32'h0202_0102;
   localparam logic [NumSources-1:0] SOURCE_MASK  = 6'h3F;

   // Mode flag positions
   localparam int unsigned MODE_REPEAT = 0;
   localparam int unsigned MODE_EBUS   = 1;
   localparam int unsigned MODE_UPPER  = 2;

   typedef enum logic [ActionWidth-1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_RAISE = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [RegIndexWidth-1:0] {
      REG_MODE    = 2'd0,
      REG_VERSION = 2'd1,
      REG_PENDING = 2'd2,
      REG_MASK    = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      CMD_HOLD   = 2'd0,
      CMD_CLEAR  = 2'd1,
      CMD_SET    = 2'd2,
      CMD_HOLD_B = 2'd3
   } flag_cmd_type;

   // Apply a two-bit flag command to one bit
   function automatic logic apply_cmd(input logic cur, input logic [1:0] cmd);
      logic res;
      res = cur;
      if (cmd == CMD_CLEAR) begin
         res = 1'b0;
      end else if (cmd == CMD_SET) begin
         res = 1'b1;
      end
      return res;
   endfunction

endpackage

FILE: design/imc_if.sv
interface imc_req_if
   import imc_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [ActionWidth-1:0]   action;
   logic [RegIndexWidth-1:0] reg_index;
   logic [DataWidth-1:0]     write_data;
   logic [SourceWidth-1:0]   irq_source;

   modport source (output valid, output action, output reg_index,
                   output write_data, output irq_source, input ready);
   modport sink   (input valid, input action, input reg_index,
                   input write_data, input irq_source, output ready);
endinterface

interface imc_rsp_if
   import imc_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [DataWidth-1:0]   read_data;
   logic                   access_error;
   logic                   irq_line;
   logic [RepeatWidth-1:0] repeat_count_out;
   logic [ModeWidth-1:0]   mode_flags;

   modport source (output valid, output read_data, output access_error,
                   output irq_line, output repeat_count_out, output mode_flags,
                   input ready);
   modport sink   (input valid, input read_data, input access_error,
                   input irq_line, input repeat_count_out, input mode_flags,
                   output ready);
endinterface

FILE: design/interrupt_mask_controller_regs.sv
// Interrupt controller with mode, version, pending and mask registers. Each
// request is a bus read, a bus write, or an interrupt raise or clear from one
// of six sources, and yields one response carrying the read data, an access
// error flag, the interrupt line and the current mode state. Requests pass an
// input register and a response register; state is updated as a request moves
// between them, so one request is taken every cycle while the response side
// keeps up; responses leave from the response register. The response register
// lets a new request be taken while an earlier response still waits.
module interrupt_mask_controller_regs
   import imc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   imc_req_if.sink   req_chan,
   imc_rsp_if.source rsp_chan
);

   // Input register
   logic                     s1_valid_ff, s1_valid_in;
   action_type               s1_action_ff;
   reg_index_type            s1_reg_ff;
   logic [DataWidth-1:0]     s1_data_ff;
   logic [SourceWidth-1:0]   s1_source_ff;

   // Controller state
   logic [NumSources-1:0]    pending_ff, pending_in;
   logic [NumSources-1:0]    enable_ff, enable_in;
   logic [RepeatWidth-1:0]   repeat_ff, repeat_in;
   logic [ModeWidth-1:0]     mode_ff, mode_in;

   // Response register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DataWidth-1:0]     rsp_rdata_ff, rsp_rdata_in;
   logic                     rsp_err_ff, rsp_err_in;
   logic                     rsp_irq_ff;

   logic                     s1_adv;
   logic                     req_take;
   logic                     src_ok;

   assign s1_adv   = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign src_ok   = s1_source_ff < SourceWidth'(NumSources);

   // Decode the held request and compute next state and response
   always_comb begin
      pending_in   = pending_ff;
      enable_in    = enable_ff;
      repeat_in    = repeat_ff;
      mode_in      = mode_ff;
      rsp_rdata_in = '0;
      rsp_err_in   = 1'b0;
      unique case (s1_action_ff)
         ACT_READ: begin
            unique case (s1_reg_ff)
               REG_VERSION: rsp_rdata_in = VERSION_WORD;
               REG_PENDING: rsp_rdata_in = DataWidth'(pending_ff);
               REG_MASK:    rsp_rdata_in = DataWidth'(enable_ff);
               REG_MODE:    rsp_err_in   = 1'b1;
            endcase
         end
         ACT_WRITE: begin
            unique case (s1_reg_ff)
               REG_MODE: begin
                  repeat_in = {1'b0, s1_data_ff[5:0]} + RepeatWidth'(1);
                  mode_in[MODE_REPEAT] = apply_cmd(mode_ff[MODE_REPEAT], s1_data_ff[8:7]);
                  mode_in[MODE_EBUS]   = apply_cmd(mode_ff[MODE_EBUS], s1_data_ff[10:9]);
                  mode_in[MODE_UPPER]  = apply_cmd(mode_ff[MODE_UPPER], s1_data_ff[13:12]);
               end
               REG_MASK: begin
                  for (int k = 0; k < NumSources; k++) begin
                     enable_in[k] = apply_cmd(enable_ff[k], s1_data_ff[2*k +: 2]);
                  end
               end
               REG_VERSION, REG_PENDING: rsp_err_in = 1'b1;
            endcase
         end
         ACT_RAISE: begin
            if (src_ok) begin
               pending_in[s1_source_ff] = 1'b1;
            end
         end
         ACT_CLEAR: begin
            if (src_ok) begin
               pending_in[s1_source_ff] = 1'b0;
            end
         end
      endcase
   end

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_chan.ready);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pending_ff   <= '0;
         enable_ff    <= '0;
         repeat_ff    <= '0;
         mode_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            pending_ff <= pending_in;
            enable_ff  <= enable_in;
            repeat_ff  <= repeat_in;
            mode_ff    <= mode_in;
         end
      end
   end

   // Capture the request into the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_action_ff <= ACT_READ;
         s1_reg_ff    <= REG_MODE;
         s1_data_ff   <= '0;
         s1_source_ff <= '0;
      end else if (req_take) begin
         s1_action_ff <= action_type'(req_chan.action);
         s1_reg_ff    <= reg_index_type'(req_chan.reg_index);
         s1_data_ff   <= req_chan.write_data;
         s1_source_ff <= req_chan.irq_source;
      end
   end

   // Load the response register as the request advances
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_rdata_ff <= rsp_rdata_in;
         rsp_err_ff   <= rsp_err_in;
         rsp_irq_ff   <= |(pending_in & enable_in);
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.read_data        = rsp_rdata_ff;
   assign rsp_chan.access_error     = rsp_err_ff;
   assign rsp_chan.irq_line         = rsp_irq_ff;
   assign rsp_chan.repeat_count_out = repeat_ff;
   assign rsp_chan.mode_flags       = mode_ff;

   // An erroneous access never returns data
   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_rdata_ff == '0)
      else $error("access error with nonzero read data");

   // Interrupt line in a fresh response matches the state it was built with
   a_irq_state: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_irq_ff == |(pending_ff & enable_ff))
      else $error("interrupt line disagrees with pending and mask");

   // Repeat count stays within its range
   a_repeat_range: assert property (@(posedge clock) disable iff (reset)
      repeat_ff <= RepeatWidth'(64))
      else $error("repeat count out of range");

   // State changes only when a request advances
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_adv |=> $stable(pending_ff) && $stable(enable_ff) && $stable(mode_ff))
      else $error("state changed without a request");

endmodule

FILE: test/tb_top.sv
module tb_top;
   import imc_pkg::*;

   localparam int unsigned CYCLE_LIMIT      = 200000;
   localparam int unsigned RANDOM_PER_PHASE = 306;
   localparam int unsigned HOLD_CYCLES      = 90;
   localparam int unsigned DRAIN_CYCLES     = 8;
   localparam int unsigned MAX_PRINTED      = 40;

   typedef struct packed {
      action_type               action;
      reg_index_type            reg_index;
      logic [DataWidth-1:0]     write_data;
      logic [SourceWidth-1:0]   source;
   } imc_request_type;

   typedef struct packed {
      logic [DataWidth-1:0]     read_data;
      logic                     access_error;
      logic                     irq_line;
      logic [RepeatWidth-1:0]   repeat_count;
      logic [ModeWidth-1:0]     mode_flags;
   } imc_response_type;

   typedef struct {
      imc_request_type  req;
      bit               typed;
      imc_response_type rsp;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   imc_req_if req_bus ();
   imc_rsp_if rsp_bus ();

   interrupt_mask_controller_regs DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Shadow copy of the controller state
   logic [NumSources-1:0]  pending_model;
   logic [NumSources-1:0]  enable_model;
   logic [RepeatWidth-1:0] repeat_model;
   logic [ModeWidth-1:0]   mode_model;

   imc_response_type expected_rsp_q[$];
   directed_row_type directed_rows[$];

   int unsigned send_idle_pct  = 0;
   int unsigned rx_stall_pct   = 0;
   int unsigned rx_hold_left   = 0;
   int unsigned mismatch_count = 0;
   int unsigned response_count = 0;
   int unsigned read_count     = 0;
   int unsigned write_count    = 0;
   int unsigned event_count    = 0;
   int unsigned error_count    = 0;
   int unsigned irq_count      = 0;
   int unsigned cycle_count    = 0;

   int unsigned idle_plan[4]  = '{0, 52, 0, 20};
   int unsigned stall_plan[4] = '{0, 0, 52, 20};

   // Free-running clock
   initial begin
      forever begin
         #4 clock = ~clock;
      end
   end

   // Give up once the cycle budget is spent
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("interrupt_mask_controller_regs test failed");
      $finish;
   end

   // One line per mismatch, counted always, printed up to a cap
   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTED) begin
         $display("MISMATCH at cycle %0d, response %0d: %s", cycle_count, response_count, msg);
      end
      mismatch_count++;
   endtask

   // New value of one flag under a two-bit command
   function automatic logic steer_flag(input logic cur, input flag_cmd_type cmd);
      logic nxt;
      case (cmd)
         CMD_CLEAR: nxt = 1'b0;
         CMD_SET:   nxt = 1'b1;
         default:   nxt = cur;
      endcase
      return nxt;
   endfunction

   // Update the shadow state with one request and return the response it gives
   function automatic imc_response_type predict_response(input imc_request_type r);
      imc_response_type p;
      p = '0;
      case (r.action)
         ACT_READ: begin
            case (r.reg_index)
               REG_VERSION: p.read_data = VERSION_WORD;
               REG_PENDING: p.read_data[NumSources-1:0] = pending_model;
               REG_MASK:    p.read_data[NumSources-1:0] = enable_model;
               default:     p.access_error = 1'b1;
            endcase
         end
         ACT_WRITE: begin
            case (r.reg_index)
               REG_MODE: begin
                  repeat_model = {1'b0, r.write_data[5:0]} + 7'd1;
                  mode_model[MODE_REPEAT] = steer_flag(mode_model[MODE_REPEAT],
                                                       flag_cmd_type'(r.write_data[8:7]));
                  mode_model[MODE_EBUS]   = steer_flag(mode_model[MODE_EBUS],
                                                       flag_cmd_type'(r.write_data[10:9]));
                  mode_model[MODE_UPPER]  = steer_flag(mode_model[MODE_UPPER],
                                                       flag_cmd_type'(r.write_data[13:12]));
               end
               REG_MASK: begin
                  for (int k = 0; k < NumSources; k++) begin
                     enable_model[k] = steer_flag(enable_model[k],
                                                  flag_cmd_type'(r.write_data[2*k +: 2]));
                  end
               end
               default: p.access_error = 1'b1;
            endcase
         end
         default: begin
            // Sources above the last one are ignored
            if (r.source < NumSources) begin
               pending_model[r.source] = (r.action == ACT_RAISE);
            end
         end
      endcase
      p.irq_line     = |(pending_model & enable_model);
      p.repeat_count = repeat_model;
      p.mode_flags   = mode_model;
      return p;
   endfunction

   function automatic imc_request_type random_request();
      imc_request_type r;
      r.action    = action_type'($urandom_range(3));
      r.reg_index = reg_index_type'($urandom_range(3));
      case ($urandom_range(4))
         0:       r.write_data = '0;
         1:       r.write_data = '1;
         2:       r.write_data = 32'($urandom_range(16383));
         default: r.write_data = $urandom();
      endcase
      r.source = 3'($urandom_range(7));
      return r;
   endfunction

   // Offer one request after a random gap, wait for it to be taken, log the expectation
   task automatic send_request(input imc_request_type r, input bit typed,
                               input imc_response_type typed_rsp);
      imc_response_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.action     <= r.action;
      req_bus.reg_index  <= r.reg_index;
      req_bus.write_data <= r.write_data;
      req_bus.irq_source <= r.source;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      predicted = predict_response(r);
      if (typed) begin
         predicted = typed_rsp;
      end
      expected_rsp_q.push_back(predicted);
      case (r.action)
         ACT_READ:  read_count++;
         ACT_WRITE: write_count++;
         default:   event_count++;
      endcase
      if (predicted.access_error) begin
         error_count++;
      end
      if (predicted.irq_line) begin
         irq_count++;
      end
   endtask

   task automatic add_row(input action_type act, input reg_index_type idx,
                          input logic [DataWidth-1:0] data, input logic [SourceWidth-1:0] src);
      directed_row_type row;
      row.req   = '{act, idx, data, src};
      row.typed = 1'b0;
      row.rsp   = '0;
      directed_rows.push_back(row);
   endtask

   // Rows whose response is known outright: state is still all zero here
   task automatic add_typed_row(input action_type act, input reg_index_type idx,
                                input logic [DataWidth-1:0] data,
                                input logic [SourceWidth-1:0] src,
                                input logic [DataWidth-1:0] rdata, input logic err);
      directed_row_type row;
      row.req   = '{act, idx, data, src};
      row.typed = 1'b1;
      row.rsp   = '0;
      row.rsp.read_data    = rdata;
      row.rsp.access_error = err;
      directed_rows.push_back(row);
   endtask

   // Compare one response with the oldest expectation
   task automatic check_response();
      imc_response_type want;
      if (expected_rsp_q.size() == 0) begin
         report_mismatch("response arrived with nothing expected");
      end else begin
         want = expected_rsp_q.pop_front();
         if (rsp_bus.read_data !== want.read_data) begin
            report_mismatch($sformatf("read_data 0x%0h, expected 0x%0h",
                                      rsp_bus.read_data, want.read_data));
         end
         if (rsp_bus.access_error !== want.access_error) begin
            report_mismatch($sformatf("access_error %0b, expected %0b",
                                      rsp_bus.access_error, want.access_error));
         end
         if (rsp_bus.irq_line !== want.irq_line) begin
            report_mismatch($sformatf("irq_line %0b, expected %0b",
                                      rsp_bus.irq_line, want.irq_line));
         end
         if (rsp_bus.repeat_count_out !== want.repeat_count) begin
            report_mismatch($sformatf("repeat_count_out %0d, expected %0d",
                                      rsp_bus.repeat_count_out, want.repeat_count));
         end
         if (rsp_bus.mode_flags !== want.mode_flags) begin
            report_mismatch($sformatf("mode_flags 0x%0h, expected 0x%0h",
                                      rsp_bus.mode_flags, want.mode_flags));
         end
      end
      response_count++;
   endtask

   // Response side: check on each transfer, then stall, hold off or accept
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            check_response();
         end
         if (rx_hold_left > 0) begin
            rx_hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   // Request side and run control
   initial begin
      req_bus.valid      <= 1'b0;
      req_bus.action     <= ACT_READ;
      req_bus.reg_index  <= REG_MODE;
      req_bus.write_data <= '0;
      req_bus.irq_source <= '0;
      pending_model = '0;
      enable_model  = '0;
      repeat_model  = '0;
      mode_model    = '0;

      // Straight after reset: reads, refused accesses, ignored sources
      add_typed_row(ACT_READ,  REG_VERSION, 32'h0,         3'd0, VERSION_WORD, 1'b0);
      add_typed_row(ACT_READ,  REG_PENDING, 32'h0,         3'd0, 32'h0,        1'b0);
      add_typed_row(ACT_READ,  REG_MASK,    32'h0,         3'd0, 32'h0,        1'b0);
      add_typed_row(ACT_READ,  REG_MODE,    32'hFFFF_FFFF, 3'd7, 32'h0,        1'b1);
      add_typed_row(ACT_WRITE, REG_VERSION, 32'hFFFF_FFFF, 3'd7, 32'h0,        1'b1);
      add_typed_row(ACT_WRITE, REG_PENDING, 32'hFFFF_FFFF, 3'd0, 32'h0,        1'b1);
      add_typed_row(ACT_RAISE, REG_MODE,    32'hFFFF_FFFF, 3'd6, 32'h0,        1'b0);
      add_typed_row(ACT_CLEAR, REG_MASK,    32'h0,         3'd7, 32'h0,        1'b0);
      // Raise with nothing enabled, enable everything, read back, then hold and clear the mask
      add_row(ACT_RAISE, REG_MODE,    32'h0,         3'd0);
      add_row(ACT_RAISE, REG_MASK,    32'hFFFF_FFFF, 3'd5);
      add_row(ACT_RAISE, REG_VERSION, 32'h0,         3'd3);
      add_row(ACT_WRITE, REG_MASK,    32'h0000_0AAA, 3'd0);
      add_row(ACT_READ,  REG_PENDING, 32'h0,         3'd0);
      add_row(ACT_READ,  REG_MASK,    32'h0,         3'd0);
      add_row(ACT_WRITE, REG_MASK,    32'hFFFF_FFFF, 3'd0);
      add_row(ACT_WRITE, REG_MASK,    32'h0000_0555, 3'd0);
      // Mode: largest count with hold, smallest with set, largest with clear, then set the repeat flag
      add_row(ACT_WRITE, REG_MODE,    32'hFFFF_FFFF, 3'd0);
      add_row(ACT_WRITE, REG_MODE,    32'h0000_2500, 3'd0);
      add_row(ACT_WRITE, REG_MODE,    32'h0000_12BF, 3'd0);
      add_row(ACT_WRITE, REG_MODE,    32'h0000_0100, 3'd0);
      // Clear sources, then a single enabled source toggling the line
      add_row(ACT_CLEAR, REG_VERSION, 32'h0,         3'd0);
      add_row(ACT_CLEAR, REG_MODE,    32'hFFFF_FFFF, 3'd5);
      add_row(ACT_WRITE, REG_MASK,    32'h0000_0800, 3'd0);
      add_row(ACT_RAISE, REG_PENDING, 32'h0,         3'd5);
      add_row(ACT_CLEAR, REG_PENDING, 32'h0,         3'd5);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
      end

      // Random traffic under each pacing, draining between phases
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = idle_plan[phase];
         rx_stall_pct  = stall_plan[phase];
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // Hold the response side off while requests keep coming
            if (phase == 0 && n == 100) begin
               rx_hold_left = HOLD_CYCLES;
            end
            send_request(random_request(), 1'b0, '0);
         end
         req_bus.valid <= 1'b0;
         while (expected_rsp_q.size() != 0) begin
            @(posedge clock);
         end
      end

      rx_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests: %0d reads, %0d writes, %0d raise/clear events",
               read_count + write_count + event_count, read_count, write_count, event_count);
      $display("%0d responses checked, %0d refused accesses, %0d with the interrupt line high",
               response_count, error_count, irq_count);
      if (mismatch_count == 0) begin
         $display("interrupt_mask_controller_regs test passed");
      end else begin
         $display("interrupt_mask_controller_regs test failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/imc_pkg.sv
design/imc_if.sv
design/interrupt_mask_controller_regs.sv
test/tb_top.sv
